// ===== src/dubiner_basis_with_gradients_unit_assert.svh =====
// Assertion macros used by the RTL of the basis unit.
`ifndef DUBINER_BASIS_WITH_GRADIENTS_UNIT_ASSERT_SVH
`define DUBINER_BASIS_WITH_GRADIENTS_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define DBG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DBG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dbg_pkg.sv =====
`default_nettype none

package dbg_pkg;

    // default fraction bits of coordinates, values and gradients
    localparam int FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int COORD_W   = 17;
    localparam int JINV_W    = 32;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 24;
    localparam int GRAD_W    = 48;
    localparam int COEF_W    = 6;
    localparam int NUM_BASIS = 10;
    localparam int NUM_VTERM = 10;

    // register stages from issue to output word, output register included
    localparam int PIPE_DEPTH = 4;

    // polynomial order codes
    localparam logic [1:0] ORDER_P0 = 2'd0;
    localparam logic [1:0] ORDER_P1 = 2'd1;
    localparam logic [1:0] ORDER_P2 = 2'd2;

    // index of the final basis function per order
    localparam logic [IDX_W-1:0] LAST_P0 = 4'd0;
    localparam logic [IDX_W-1:0] LAST_P1 = 4'd3;
    localparam logic [IDX_W-1:0] LAST_P2 = 4'd9;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic        [COORD_W-1:0] xi;
        logic        [COORD_W-1:0] eta;
        logic        [COORD_W-1:0] zeta;
        logic signed [JINV_W-1:0]  jinv_00;
        logic signed [JINV_W-1:0]  jinv_01;
        logic signed [JINV_W-1:0]  jinv_02;
        logic signed [JINV_W-1:0]  jinv_10;
        logic signed [JINV_W-1:0]  jinv_11;
        logic signed [JINV_W-1:0]  jinv_12;
        logic signed [JINV_W-1:0]  jinv_20;
        logic signed [JINV_W-1:0]  jinv_21;
        logic signed [JINV_W-1:0]  jinv_22;
    } t_in_word;

    typedef struct packed {
        logic        [IDX_W-1:0]  basis_index;
        logic signed [VAL_W-1:0]  basis_value;
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic signed [GRAD_W-1:0] grad_z;
        logic                     last;
    } t_out_word;

    // control that travels alongside the datapath stages
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_tag;

    // value coefficients, terms: xx, yy, zz, xy, xz, yz, x, y, z, 1
    localparam t_coef VAL_COEF [NUM_BASIS][NUM_VTERM] = '{
        '{0, 0,  0,  0,  0,  0,  0,  0,   0,  1},
        '{0, 0,  0,  0,  0,  0,  2,  1,   1, -1},
        '{0, 0,  0,  0,  0,  0,  0,  3,   1, -1},
        '{0, 0,  0,  0,  0,  0,  0,  0,   4, -1},
        '{6, 1,  1,  6,  6,  2, -6, -2,  -2,  1},
        '{0, 5,  1, 10,  2,  6, -2, -6,  -2,  1},
        '{0, 0,  6,  0, 12,  6, -2, -1,  -7,  1},
        '{0, 10, 1,  0,  0,  8,  0, -8,  -2,  1},
        '{0, 0,  6,  0,  0, 18,  0, -3,  -7,  1},
        '{0, 0, 15,  0,  0,  0,  0,  0, -10,  1}
    };

    // reference derivative coefficients [basis][d/dxi,d/deta,d/dzeta][x,y,z,1]
    localparam t_coef DER_COEF [NUM_BASIS][3][4] = '{
        '{'{ 0,  0,  0,  0}, '{ 0,  0,  0,  0}, '{ 0,  0,  0,   0}},
        '{'{ 0,  0,  0,  2}, '{ 0,  0,  0,  1}, '{ 0,  0,  0,   1}},
        '{'{ 0,  0,  0,  0}, '{ 0,  0,  0,  3}, '{ 0,  0,  0,   1}},
        '{'{ 0,  0,  0,  0}, '{ 0,  0,  0,  0}, '{ 0,  0,  0,   4}},
        '{'{12,  6,  6, -6}, '{ 6,  2,  2, -2}, '{ 6,  2,  2,  -2}},
        '{'{ 0, 10,  2, -2}, '{10, 10,  6, -6}, '{ 2,  6,  2,  -2}},
        '{'{ 0,  0, 12, -2}, '{ 0,  0,  6, -1}, '{12,  6, 12,  -7}},
        '{'{ 0,  0,  0,  0}, '{ 0, 20,  8, -8}, '{ 0,  8,  2,  -2}},
        '{'{ 0,  0,  0,  0}, '{ 0,  0, 18, -3}, '{ 0, 18, 12,  -7}},
        '{'{ 0,  0,  0,  0}, '{ 0,  0,  0,  0}, '{ 0,  0, 30, -10}}
    };

    // final basis index for an order code; the spare code acts as order 2
    function automatic logic [IDX_W-1:0] last_index(input logic [1:0] order);
        logic [IDX_W-1:0] res;
        case (order)
            ORDER_P0: res = LAST_P0;
            ORDER_P1: res = LAST_P1;
            default:  res = LAST_P2;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/dubiner_basis_with_gradients_unit.sv =====
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+-----------------------------------
//  in      | input     | i_in_valid/o_in_stall   | t_in_word: point, inverse Jacobian
//  out     | output    | o_out_valid/i_out_stall | t_out_word: one basis function
//  cfg     | input     | i_cfg_valid/o_cfg_ready | poly_order, 2 bits
//
//  A point yields 1, 4 or 10 words (order 0, 1, 2), one per cycle from the issue stage
//  while no word is held; the next point is taken in the cycle the final index issues.
//  The issue register loads at the accepting edge and four datapath stages follow, the
//  last being the output register. A held output word freezes every stage at once;
//  nothing is dropped or repeated. Reset (synchronous, active low) empties the pipe
//  and sets poly_order to 2.
`default_nettype none

`include "dubiner_basis_with_gradients_unit_assert.svh"

module dubiner_basis_with_gradients_unit #(
    parameter int FRAC_BITS = dbg_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire dbg_pkg::t_in_word  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output dbg_pkg::t_out_word      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_data
);

    localparam int DEPTH = dbg_pkg::PIPE_DEPTH;
    localparam int VW    = dbg_pkg::VAL_W;
    localparam logic signed [VW-1:0] ONE_VAL =
        VW'((FRAC_BITS < VW - 1) ? (1 << FRAC_BITS) : ((1 << (VW - 1)) - 1));

    logic [1:0]                          r_poly_order;
    logic                                w_en;
    dbg_pkg::t_tag                       w_issue;
    dbg_pkg::t_in_word                   w_point;
    dbg_pkg::t_tag                       r_tag [DEPTH];
    logic signed [VW-1:0]                w_value;
    logic signed [dbg_pkg::GRAD_W-1:0]   w_gx;
    logic signed [dbg_pkg::GRAD_W-1:0]   w_gy;
    logic signed [dbg_pkg::GRAD_W-1:0]   w_gz;
    logic [dbg_pkg::IDX_W-1:0]           w_idx_succ;
    logic                                w_out_acc;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly_order <= dbg_pkg::ORDER_P2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_poly_order <= i_cfg_data;
        end
    end

    // the whole pipe advances unless a finished word is held
    assign w_en = !r_tag[DEPTH-1].vld || !i_out_stall;

    dbg_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_poly_order (r_poly_order),
        .o_tag        (w_issue),
        .o_point      (w_point)
    );

    dbg_val_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_val (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_idx   (w_issue.idx),
        .i_point (w_point),
        .o_value (w_value)
    );

    dbg_grad_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_grad (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_idx    (w_issue.idx),
        .i_point  (w_point),
        .o_grad_x (w_gx),
        .o_grad_y (w_gy),
        .o_grad_z (w_gz)
    );

    // valid, index and last travel beside the datapath stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DEPTH; s++) begin
                r_tag[s] <= '0;
            end
        end else if (w_en) begin
            r_tag[0] <= w_issue;
            for (int s = 1; s < DEPTH; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    // output word
    assign o_out_valid             = r_tag[DEPTH-1].vld;
    assign o_out_data.basis_index  = r_tag[DEPTH-1].idx;
    assign o_out_data.basis_value  = w_value;
    assign o_out_data.grad_x       = w_gx;
    assign o_out_data.grad_y       = w_gy;
    assign o_out_data.grad_z       = w_gz;
    assign o_out_data.last         = r_tag[DEPTH-1].last;

    assign w_out_acc  = o_out_valid && !i_out_stall;
    assign w_idx_succ = o_out_data.basis_index + dbg_pkg::IDX_W'(1);

    // checks
    `DBG_ASSERT_SAME(a_last_idx, i_clk, i_rst_n,
        o_out_valid && o_out_data.last,
        o_out_data.basis_index == dbg_pkg::last_index(r_poly_order),
        "last flag on a basis index that does not end the order")
    `DBG_ASSERT_SAME(a_basis0, i_clk, i_rst_n,
        o_out_valid && (o_out_data.basis_index == '0),
        (o_out_data.basis_value == ONE_VAL) && (o_out_data.grad_x == '0)
            && (o_out_data.grad_y == '0) && (o_out_data.grad_z == '0),
        "basis 0 is not one with zero gradient")
    `DBG_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n,
        w_out_acc && !o_out_data.last,
        o_out_valid && (o_out_data.basis_index == $past(w_idx_succ)),
        "basis index did not step by one within a point")

endmodule

`default_nettype wire

// ===== src/dbg_seq.sv =====
`default_nettype none

// Issue stage: holds one point and steps through its basis indexes.
module dbg_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire dbg_pkg::t_in_word i_in_data,
    input  wire logic [1:0]        i_poly_order,
    output dbg_pkg::t_tag          o_tag,
    output dbg_pkg::t_in_word      o_point
);

    logic                        r_busy;
    logic [dbg_pkg::IDX_W-1:0]   r_idx;
    dbg_pkg::t_in_word           r_point;
    logic                        w_is_last;
    logic                        w_accept;

    assign w_is_last = (r_idx == dbg_pkg::last_index(i_poly_order));

    // a new point may load as the final index of the current one leaves
    assign o_in_stall = r_busy && !(i_en && w_is_last);
    assign w_accept   = i_in_valid && !o_in_stall;

    // index counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (i_en && r_busy) begin
            if (w_is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + dbg_pkg::IDX_W'(1);
            end
        end
    end

    // point register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_point <= i_in_data;
        end
    end

    assign o_tag.vld  = r_busy;
    assign o_tag.idx  = r_idx;
    assign o_tag.last = w_is_last;
    assign o_point    = r_point;

endmodule

`default_nettype wire

// ===== src/dbg_val_pipe.sv =====
`default_nettype none

// Basis value: products, coefficient partial sums, total, round and saturate.
module dbg_val_pipe #(
    parameter int FRAC_BITS = dbg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic [dbg_pkg::IDX_W-1:0]        i_idx,
    input  wire dbg_pkg::t_in_word                i_point,
    output logic signed [dbg_pkg::VAL_W-1:0]      o_value
);

    localparam int CW     = dbg_pkg::COORD_W;
    localparam int TERM_W = 2 * CW;
    localparam int LIN_W  = CW + FRAC_BITS;
    localparam int ONE2_W = 2 * FRAC_BITS + 1;
    localparam int MAX_AB = (TERM_W > LIN_W) ? TERM_W : LIN_W;
    localparam int MAX_W  = (MAX_AB > ONE2_W) ? MAX_AB : ONE2_W;
    // coefficient magnitudes of one row sum below 64
    localparam int VSUM_W = MAX_W + 7;

    localparam logic signed [VSUM_W-1:0] HALF = VSUM_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [VSUM_W-1:0] V_HI =
        (VSUM_W'(1) <<< (dbg_pkg::VAL_W - 1)) - VSUM_W'(1);
    localparam logic signed [VSUM_W-1:0] V_LO = ~V_HI;

    logic [CW-1:0]              w_c [3];
    logic [TERM_W-1:0]          r1_t [6];
    logic [CW-1:0]              r1_c [3];
    logic [dbg_pkg::IDX_W-1:0]  r1_idx;
    logic signed [VSUM_W-1:0]   n_tv [6];
    logic signed [VSUM_W-1:0]   n_lin [3];
    logic signed [VSUM_W-1:0]   n_const;
    logic signed [VSUM_W-1:0]   r2_part [3];
    logic signed [VSUM_W-1:0]   r3_sum;
    logic signed [VSUM_W-1:0]   n_rnd;
    logic signed [VSUM_W-1:0]   n_q;
    logic signed [dbg_pkg::VAL_W-1:0] n_val;
    logic signed [dbg_pkg::VAL_W-1:0] r4_val;

    assign w_c[0] = i_point.xi;
    assign w_c[1] = i_point.eta;
    assign w_c[2] = i_point.zeta;

    // stage 1: second-order coordinate products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t[0] <= w_c[0] * w_c[0];
            r1_t[1] <= w_c[1] * w_c[1];
            r1_t[2] <= w_c[2] * w_c[2];
            r1_t[3] <= w_c[0] * w_c[1];
            r1_t[4] <= w_c[0] * w_c[2];
            r1_t[5] <= w_c[1] * w_c[2];
            r1_c    <= w_c;
            r1_idx  <= i_idx;
        end
    end

    // stage 2: scale each term by its coefficient, three partial sums
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            n_tv[j] = $signed(VSUM_W'(r1_t[j]))
                    * VSUM_W'(dbg_pkg::VAL_COEF[r1_idx][j]);
        end
        for (int j = 0; j < 3; j++) begin
            n_lin[j] = ($signed(VSUM_W'(r1_c[j]))
                     * VSUM_W'(dbg_pkg::VAL_COEF[r1_idx][6 + j])) <<< FRAC_BITS;
        end
        n_const = VSUM_W'(dbg_pkg::VAL_COEF[r1_idx][9]) <<< (2 * FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_part[0] <= n_tv[0] + n_tv[1] + n_tv[2];
            r2_part[1] <= n_tv[3] + n_tv[4] + n_tv[5];
            r2_part[2] <= n_lin[0] + n_lin[1] + n_lin[2] + n_const;
        end
    end

    // stage 3: total at twice the fraction bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sum <= r2_part[0] + r2_part[1] + r2_part[2];
        end
    end

    // stage 4: round half up, then clamp to the output width
    always_comb begin
        n_rnd = r3_sum + HALF;
        n_q   = n_rnd >>> FRAC_BITS;
        if (n_q > V_HI) begin
            n_val = V_HI[dbg_pkg::VAL_W-1:0];
        end else if (n_q < V_LO) begin
            n_val = V_LO[dbg_pkg::VAL_W-1:0];
        end else begin
            n_val = n_q[dbg_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_val <= n_val;
        end
    end

    assign o_value = r4_val;

endmodule

`default_nettype wire

// ===== src/dbg_grad_pipe.sv =====
`default_nettype none

// Physical gradient: reference derivative, Jacobian products, sum, round and clamp.
module dbg_grad_pipe #(
    parameter int FRAC_BITS = dbg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic [dbg_pkg::IDX_W-1:0]        i_idx,
    input  wire dbg_pkg::t_in_word                i_point,
    output logic signed [dbg_pkg::GRAD_W-1:0]     o_grad_x,
    output logic signed [dbg_pkg::GRAD_W-1:0]     o_grad_y,
    output logic signed [dbg_pkg::GRAD_W-1:0]     o_grad_z
);

    localparam int CW    = dbg_pkg::COORD_W;
    localparam int JW    = dbg_pkg::JINV_W;
    localparam int GW    = dbg_pkg::GRAD_W;
    localparam int MAX_W = (CW > FRAC_BITS + 1) ? CW : FRAC_BITS + 1;
    // derivative coefficient magnitudes of one row sum below 64
    localparam int D_W   = MAX_W + 7;
    localparam int P_W   = D_W + JW;
    localparam int GS_W  = P_W + 2;

    localparam logic signed [GS_W-1:0] HALF = GS_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [GS_W-1:0] G_HI = (GS_W'(1) <<< (GW - 1)) - GS_W'(1);
    localparam logic signed [GS_W-1:0] G_LO = ~G_HI;

    logic [CW-1:0]             w_c [3];
    logic signed [JW-1:0]      w_j [3][3];
    logic signed [D_W-1:0]     n_d [3];
    logic signed [D_W-1:0]     r1_d [3];
    logic signed [JW-1:0]      r1_j [3][3];
    logic signed [P_W-1:0]     r2_p [3][3];
    logic signed [GS_W-1:0]    r3_g [3];
    logic signed [GS_W-1:0]    n_rnd [3];
    logic signed [GS_W-1:0]    n_q [3];
    logic signed [GW-1:0]      n_g [3];
    logic signed [GW-1:0]      r4_g [3];

    assign w_c[0]    = i_point.xi;
    assign w_c[1]    = i_point.eta;
    assign w_c[2]    = i_point.zeta;
    assign w_j[0][0] = i_point.jinv_00;
    assign w_j[0][1] = i_point.jinv_01;
    assign w_j[0][2] = i_point.jinv_02;
    assign w_j[1][0] = i_point.jinv_10;
    assign w_j[1][1] = i_point.jinv_11;
    assign w_j[1][2] = i_point.jinv_12;
    assign w_j[2][0] = i_point.jinv_20;
    assign w_j[2][1] = i_point.jinv_21;
    assign w_j[2][2] = i_point.jinv_22;

    // stage 1: reference derivatives, linear in the coordinates
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_d[r] = $signed(D_W'(w_c[0])) * D_W'(dbg_pkg::DER_COEF[i_idx][r][0])
                   + $signed(D_W'(w_c[1])) * D_W'(dbg_pkg::DER_COEF[i_idx][r][1])
                   + $signed(D_W'(w_c[2])) * D_W'(dbg_pkg::DER_COEF[i_idx][r][2])
                   + (D_W'(dbg_pkg::DER_COEF[i_idx][r][3]) <<< FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d <= n_d;
            r1_j <= w_j;
        end
    end

    // stage 2: nine derivative by Jacobian products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int col = 0; col < 3; col++) begin
                    r2_p[r][col] <= P_W'(r1_d[r]) * P_W'(r1_j[r][col]);
                end
            end
        end
    end

    // stage 3: sum over reference directions per column
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int col = 0; col < 3; col++) begin
                r3_g[col] <= GS_W'(r2_p[0][col]) + GS_W'(r2_p[1][col])
                           + GS_W'(r2_p[2][col]);
            end
        end
    end

    // stage 4: round half up, then clamp
    always_comb begin
        for (int col = 0; col < 3; col++) begin
            n_rnd[col] = r3_g[col] + HALF;
            n_q[col]   = n_rnd[col] >>> FRAC_BITS;
            if (n_q[col] > G_HI) begin
                n_g[col] = G_HI[GW-1:0];
            end else if (n_q[col] < G_LO) begin
                n_g[col] = G_LO[GW-1:0];
            end else begin
                n_g[col] = n_q[col][GW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_g <= n_g;
        end
    end

    assign o_grad_x = r4_g[0];
    assign o_grad_y = r4_g[1];
    assign o_grad_z = r4_g[2];

endmodule

`default_nettype wire
